// ----- rtl/cds_pkg.sv -----
// Shared types, constants and helpers for the calendar date stepper.
package cds_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;

  localparam int MAX_YEAR       = 9999;
  localparam int YEAR_FIELD_MAX = (1 << YEAR_W) - 1;
  localparam int TOP_YEAR_INT   = (MAX_YEAR < YEAR_FIELD_MAX) ? MAX_YEAR : YEAR_FIELD_MAX;
  localparam logic [YEAR_W-1:0] TOP_YEAR   = YEAR_W'(TOP_YEAR_INT);
  localparam logic [YEAR_W-1:0] FIRST_YEAR = YEAR_W'(1);

  // year / 25 by reciprocal: floor(y * ceil(2^19 / 25) / 2^19) is exact for y < 2^14
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_25 =
    RECIP_W'(((1 << RECIP_SHIFT) + 24) / 25);
  localparam int PROD_W = YEAR_W + RECIP_W;
  localparam int Q_W    = PROD_W - RECIP_SHIFT;

  localparam logic MODE_NEXT = 1'b0;
  localparam logic MODE_PREV = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0] LEN_28    = DAY_W'(28);
  localparam logic [DAY_W-1:0] LEN_29    = DAY_W'(29);
  localparam logic [DAY_W-1:0] LEN_30    = DAY_W'(30);
  localparam logic [DAY_W-1:0] LEN_31    = DAY_W'(31);

  typedef struct packed {
    logic               mode;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cds_item_t;

  typedef struct packed {
    cds_item_t        item;
    logic [Q_W-1:0]   quot25;
  } cds_s1_t;

  typedef struct packed {
    cds_item_t        item;
    logic             valid;
    logic [DAY_W-1:0] len;
    logic [DAY_W-1:0] prev_len;
  } cds_s2_t;

  typedef struct packed {
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic               date_valid;
    logic [DAY_W-1:0]   month_length;
    logic               range_error;
  } cds_result_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = LEN_31;
    case (m) inside
      MONTH_FEB:                                 len = leap ? LEN_29 : LEN_28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
      default:                                   len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/cds_if.sv -----
// Handshake channels for date beats and result beats.
interface cds_in_if import cds_pkg::*;;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;

  modport source(output valid, mode, day, month, year, input ready);
  modport sink(input valid, mode, day, month, year, output ready);
endinterface

interface cds_out_if import cds_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;
  logic               date_valid;
  logic [DAY_W-1:0]   month_length;
  logic               range_error;

  modport source(output valid, out_day, out_month, out_year, date_valid, month_length,
                 range_error, input ready);
  modport sink(input valid, out_day, out_month, out_year, date_valid, month_length,
               range_error, output ready);
endinterface

// ----- rtl/cds_recip.sv -----
// Stage 1: year divided by 25 through a reciprocal multiply.
module cds_recip import cds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  cds_item_t in_item,
  output logic      in_ready,
  output logic      out_valid,
  output cds_s1_t   out_data,
  input  logic      out_ready
);

  logic [PROD_W-1:0] prod;

  assign prod     = PROD_W'(in_item.year) * PROD_W'(RECIP_25);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data.item   <= in_item;
      out_data.quot25 <= prod[PROD_W-1:RECIP_SHIFT];
    end
  end

endmodule

// ----- rtl/cds_check.sv -----
// Stage 2: leap rule, month lengths and date validity.
module cds_check import cds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  cds_s1_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  output cds_s2_t out_data,
  input  logic    out_ready
);

  logic [YEAR_W-1:0]  q;
  logic [YEAR_W-1:0]  rem25;
  logic               div25;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic [DAY_W-1:0]   prev_len;
  logic               date_ok;
  logic [MONTH_W-1:0] prev_month;

  assign q          = YEAR_W'(in_data.quot25);
  assign rem25      = in_data.item.year - ((q << 4) + (q << 3) + q);
  assign div25      = (rem25 == '0);
  assign leap       = (in_data.item.year[1:0] == 2'b00 && !div25) ||
                      (in_data.item.year[3:0] == 4'b0000 && div25);
  assign prev_month = in_data.item.month - MONTH_JAN;
  assign len        = month_len(in_data.item.month, leap);
  assign prev_len   = month_len(prev_month, leap);
  assign date_ok    = (in_data.item.year >= FIRST_YEAR) && (in_data.item.year <= TOP_YEAR) &&
                      (in_data.item.month inside {[MONTH_JAN:MONTH_DEC]}) &&
                      (in_data.item.day >= DAY_FIRST) && (in_data.item.day <= len);
  assign in_ready   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data.item     <= in_data.item;
      out_data.valid    <= date_ok;
      out_data.len      <= len;
      out_data.prev_len <= prev_len;
    end
  end

endmodule

// ----- rtl/cds_step.sv -----
// Stage 3: next or previous day with rollover, held in the output register.
module cds_step import cds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  cds_s2_t     in_data,
  output logic        in_ready,
  output logic        out_valid,
  output cds_result_t out_data,
  input  logic        out_ready
);

  cds_result_t res;

  always_comb begin
    res.out_day      = in_data.item.day;
    res.out_month    = in_data.item.month;
    res.out_year     = in_data.item.year;
    res.date_valid   = in_data.valid;
    res.month_length = in_data.len;
    res.range_error  = 1'b0;
    if (in_data.valid) begin
      if (in_data.item.mode == MODE_NEXT) begin
        if (in_data.item.day == in_data.len) begin
          if (in_data.item.month == MONTH_DEC) begin
            if (in_data.item.year >= TOP_YEAR) begin
              res.range_error = 1'b1;
            end else begin
              res.out_day   = DAY_FIRST;
              res.out_month = MONTH_JAN;
              res.out_year  = in_data.item.year + FIRST_YEAR;
            end
          end else begin
            res.out_day   = DAY_FIRST;
            res.out_month = in_data.item.month + MONTH_JAN;
          end
        end else begin
          res.out_day = in_data.item.day + DAY_FIRST;
        end
      end else begin
        if (in_data.item.day == DAY_FIRST) begin
          if (in_data.item.month == MONTH_JAN) begin
            if (in_data.item.year <= FIRST_YEAR) begin
              res.range_error = 1'b1;
            end else begin
              res.out_day   = LEN_31;
              res.out_month = MONTH_DEC;
              res.out_year  = in_data.item.year - FIRST_YEAR;
            end
          end else begin
            res.out_day   = in_data.prev_len;
            res.out_month = in_data.item.month - MONTH_JAN;
          end
        end else begin
          res.out_day = in_data.item.day - DAY_FIRST;
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= res;
    end
  end

endmodule

// ----- rtl/calendar_date_stepper.sv -----
// Top level of the Gregorian next/previous date stepper.
//
//   channel  dir  beat
//   din      in   mode, day, month, year
//   dout     out  out_day, out_month, out_year, date_valid, month_length, range_error
//
// One beat per cycle sustained while dout is ready; registered stages: reciprocal multiply, check, step.
// Each stage holds its own valid bit and advances when empty or when the next one moves.
// A stall on dout backs up stage by stage; nothing is dropped or repeated.
// Synchronous reset clears the valid bits only.
module calendar_date_stepper import cds_pkg::*; (
  input logic      clk,
  input logic      rst,
  cds_in_if.sink   din,
  cds_out_if.source dout
);

  cds_item_t   in_item;
  logic        s1_valid;
  logic        s1_ready;
  cds_s1_t     s1_data;
  logic        s2_valid;
  logic        s2_ready;
  cds_s2_t     s2_data;
  cds_result_t res;

  assign in_item.mode  = din.mode;
  assign in_item.day   = din.day;
  assign in_item.month = din.month;
  assign in_item.year  = din.year;

  cds_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_item  (in_item),
    .in_ready (din.ready),
    .out_valid(s1_valid),
    .out_data (s1_data),
    .out_ready(s1_ready)
  );

  cds_check u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_data  (s1_data),
    .in_ready (s1_ready),
    .out_valid(s2_valid),
    .out_data (s2_data),
    .out_ready(s2_ready)
  );

  cds_step u_step (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_data  (s2_data),
    .in_ready (s2_ready),
    .out_valid(dout.valid),
    .out_data (res),
    .out_ready(dout.ready)
  );

  assign dout.out_day      = res.out_day;
  assign dout.out_month    = res.out_month;
  assign dout.out_year     = res.out_year;
  assign dout.date_valid   = res.date_valid;
  assign dout.month_length = res.month_length;
  assign dout.range_error  = res.range_error;

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (rst)
    !dout.valid |-> din.ready)
    else $error("input stalled with empty output stage");

  a_invalid_no_range_error: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.date_valid |-> !dout.range_error)
    else $error("range error on invalid date");

  a_valid_len: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.date_valid |-> dout.month_length >= LEN_28)
    else $error("month length below 28 for valid date");

  a_step_month_ok: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.date_valid |->
      dout.out_month >= MONTH_JAN && dout.out_month <= MONTH_DEC &&
      dout.out_day >= DAY_FIRST && dout.out_year >= FIRST_YEAR)
    else $error("stepped date out of range");

endmodule

// ----- bench/calendar_date_stepper_tb.sv -----
// Self-checking testbench for the calendar date stepper: directed date table, then random dates.
`timescale 1ns / 1ps

module calendar_date_stepper_tb;
  import cds_pkg::*;

  typedef struct packed {
    cds_item_t   date;
    logic        has_want;
    cds_result_t want;
  } date_row_t;

  logic clk;
  logic rst;
  logic quiet_stretch;
  int unsigned failures = 0;
  cds_result_t expected_dates[$];
  cds_result_t oldest;

  cds_in_if din_if ();
  cds_out_if dout_if ();

  calendar_date_stepper dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_for(int unsigned m, int unsigned y);
    if (m == MONTH_FEB) return is_leap(y) ? 29 : 28;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 30;
    return 31;
  endfunction

  function automatic cds_result_t step_date(cds_item_t d);
    cds_result_t r;
    int unsigned len;
    len = days_for(d.month, d.year);
    r.out_day = d.day;
    r.out_month = d.month;
    r.out_year = d.year;
    r.date_valid = 1'b0;
    r.month_length = DAY_W'(len);
    r.range_error = 1'b0;
    if (d.year >= 1 && d.year <= TOP_YEAR_INT && d.month >= MONTH_JAN && d.month <= MONTH_DEC &&
        d.day >= DAY_FIRST && d.day <= len) begin
      r.date_valid = 1'b1;
      if (d.mode == MODE_NEXT) begin
        if (d.day != len) begin
          r.out_day = d.day + 1'b1;
        end else if (d.month != MONTH_DEC) begin
          r.out_day = DAY_FIRST;
          r.out_month = d.month + 1'b1;
        end else if (d.year >= TOP_YEAR_INT) begin
          r.range_error = 1'b1;
        end else begin
          r.out_day = DAY_FIRST;
          r.out_month = MONTH_JAN;
          r.out_year = d.year + 1'b1;
        end
      end else begin
        if (d.day != DAY_FIRST) begin
          r.out_day = d.day - 1'b1;
        end else if (d.month != MONTH_JAN) begin
          r.out_month = d.month - 1'b1;
          r.out_day = DAY_W'(days_for(d.month - 1, d.year));
        end else if (d.year <= 1) begin
          r.range_error = 1'b1;
        end else begin
          r.out_month = MONTH_DEC;
          r.out_year = d.year - 1'b1;
          r.out_day = LEN_31;
        end
      end
    end
    return r;
  endfunction

  function automatic date_row_t dated(logic mode, int unsigned d, int unsigned m,
                                      int unsigned y);
    date_row_t row;
    row.date.mode = mode;
    row.date.day = DAY_W'(d);
    row.date.month = MONTH_W'(m);
    row.date.year = YEAR_W'(y);
    row.has_want = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic date_row_t dated_want(logic mode, int unsigned d, int unsigned m,
                                           int unsigned y, logic ok, int unsigned len,
                                           logic out_of_range);
    date_row_t row;
    row = dated(mode, d, m, y);
    row.has_want = 1'b1;
    row.want.out_day = DAY_W'(d);
    row.want.out_month = MONTH_W'(m);
    row.want.out_year = YEAR_W'(y);
    row.want.date_valid = ok;
    row.want.month_length = DAY_W'(len);
    row.want.range_error = out_of_range;
    return row;
  endfunction

  function automatic cds_item_t random_date();
    cds_item_t it;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    it.mode = logic'($urandom_range(0, 1));
    if (pick < 12) begin
      it.day = DAY_W'($urandom);
      it.month = MONTH_W'($urandom);
      it.year = YEAR_W'($urandom);
      return it;
    end
    case ($urandom_range(0, 7))
      0: it.year = YEAR_W'($urandom_range(1, 3));
      1: it.year = YEAR_W'($urandom_range(TOP_YEAR_INT - 2, TOP_YEAR_INT));
      2: it.year = YEAR_W'(100 * $urandom_range(1, 99));
      3: it.year = YEAR_W'(400 * $urandom_range(1, 24));
      4: it.year = YEAR_W'(4 * $urandom_range(1, 2499));
      default: it.year = YEAR_W'($urandom_range(1, TOP_YEAR_INT));
    endcase
    case ($urandom_range(0, 5))
      0: it.month = MONTH_JAN;
      1: it.month = MONTH_FEB;
      2: it.month = MONTH_DEC;
      default: it.month = MONTH_W'($urandom_range(1, 12));
    endcase
    len = days_for(it.month, it.year);
    case ($urandom_range(0, 5))
      0: it.day = DAY_FIRST;
      1: it.day = DAY_W'(len);
      2: it.day = DAY_W'(len - 1);
      default: it.day = DAY_W'($urandom_range(1, len));
    endcase
    if (pick < 17) it.day = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
    return it;
  endfunction

  task automatic send_date(cds_item_t date, logic has_want, cds_result_t want);
    while (!quiet_stretch && $urandom_range(0, 99) < 36) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.mode <= date.mode;
    din_if.day <= date.day;
    din_if.month <= date.month;
    din_if.year <= date.year;
    do @(posedge clk); while (!din_if.ready);
    expected_dates.push_back(has_want ? want : step_date(date));
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    dout_if.ready <= quiet_stretch || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (expected_dates.size() == 0) begin
        $error("result beat with nothing expected");
        failures++;
      end else begin
        oldest = expected_dates.pop_front();
        check_field("out_day", oldest.out_day, dout_if.out_day);
        check_field("out_month", oldest.out_month, dout_if.out_month);
        check_field("out_year", oldest.out_year, dout_if.out_year);
        check_field("date_valid", oldest.date_valid, dout_if.date_valid);
        check_field("month_length", oldest.month_length, dout_if.month_length);
        check_field("range_error", oldest.range_error, dout_if.range_error);
      end
    end
  end

  initial begin
    date_row_t directed[$];
    int unsigned drain;
    rst = 1'b1;
    quiet_stretch = 1'b0;
    din_if.valid = 1'b0;
    din_if.mode = MODE_NEXT;
    din_if.day = '0;
    din_if.month = '0;
    din_if.year = '0;
    dout_if.ready = 1'b0;

    // range errors, invalid dates and bad-month lengths: results are plain echoes
    directed.push_back(dated_want(MODE_PREV, 1, 1, 1, 1'b1, 31, 1'b1));
    directed.push_back(dated_want(MODE_NEXT, 31, 12, TOP_YEAR_INT, 1'b1, 31, 1'b1));
    directed.push_back(dated_want(MODE_NEXT, 0, 1, 2000, 1'b0, 31, 1'b0));
    directed.push_back(dated_want(MODE_PREV, 31, 0, 2000, 1'b0, 31, 1'b0));
    directed.push_back(dated_want(MODE_PREV, 31, 15, 16383, 1'b0, 31, 1'b0));
    directed.push_back(dated_want(MODE_NEXT, 29, 2, 0, 1'b0, 29, 1'b0));
    directed.push_back(dated_want(MODE_NEXT, 1, 1, TOP_YEAR_INT + 1, 1'b0, 31, 1'b0));
    directed.push_back(dated_want(MODE_NEXT, 29, 2, 1900, 1'b0, 28, 1'b0));
    directed.push_back(dated_want(MODE_NEXT, 31, 4, 2023, 1'b0, 30, 1'b0));
    directed.push_back(dated_want(MODE_NEXT, 0, 0, 0, 1'b0, 31, 1'b0));
    directed.push_back(dated_want(MODE_NEXT, 1, 13, 2024, 1'b0, 31, 1'b0));
    // rollovers and leap rule in both directions
    directed.push_back(dated(MODE_NEXT, 29, 2, 2000));
    directed.push_back(dated(MODE_NEXT, 28, 2, 1900));
    directed.push_back(dated(MODE_PREV, 1, 3, 2000));
    directed.push_back(dated(MODE_PREV, 1, 3, 2100));
    directed.push_back(dated(MODE_NEXT, 31, 12, 2023));
    directed.push_back(dated(MODE_PREV, 1, 1, 2024));
    directed.push_back(dated(MODE_NEXT, 30, 4, 2023));
    directed.push_back(dated(MODE_PREV, 1, 5, 2023));
    directed.push_back(dated(MODE_PREV, 1, 1, 2));
    directed.push_back(dated(MODE_NEXT, 30, 12, TOP_YEAR_INT));
    directed.push_back(dated(MODE_NEXT, 31, 12, TOP_YEAR_INT - 1));
    directed.push_back(dated(MODE_PREV, 2, 1, 1));
    directed.push_back(dated(MODE_NEXT, 29, 2, 2024));
    directed.push_back(dated(MODE_PREV, 15, 6, TOP_YEAR_INT));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_date(directed[i].date, directed[i].has_want, directed[i].want);

    for (int i = 0; i < 1050; i++) begin
      quiet_stretch <= (i >= 400 && i < 650);
      send_date(random_date(), 1'b0, '0);
    end
    din_if.valid <= 1'b0;
    quiet_stretch <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 10) begin
      @(posedge clk);
      drain++;
    end

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- calendar_date_stepper.f -----
rtl/cds_pkg.sv
rtl/cds_if.sv
rtl/cds_recip.sv
rtl/cds_check.sv
rtl/cds_step.sv
rtl/calendar_date_stepper.sv
bench/calendar_date_stepper_tb.sv
